>>> sv/tbv_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helper functions for the terrain brush vertex update.
// No dependencies.
package tbv_pkg;

  localparam int D2_W   = 50;  // squared xz distance
  localparam int DIST_W = 25;  // integer square root of the above
  localparam int NUM_W  = 51;  // dividend of the falloff division
  localparam int DEN_W  = 30;  // divisor of the falloff division
  localparam int Q_W    = 17;  // quotient bits kept

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic       SHAPE_SQUARE = 1'b0;
  localparam logic [1:0] FALL_HARD    = 2'd0;
  localparam logic [1:0] FALL_LINEAR  = 2'd1;
  localparam logic [1:0] FALL_SINE    = 2'd2;
  localparam logic [1:0] FALL_NONE    = 2'd3;

  typedef enum logic [2:0] {
    CFG_SHAPE,
    CFG_FALLOFF,
    CFG_RADIUS,
    CFG_GAIN,
    CFG_FILL,
    CFG_PAINT,
    CFG_FLOOR,
    CFG_CEIL
  } cfg_idx_t;

  // per-vertex data that rides along the distance and divider pipes
  typedef struct packed {
    logic [23:0] h;
    logic [16:0] b;
    logic [15:0] dt;
    logic        wforce;  // weight is fixed, falloff result ignored
    logic        wone;    // fixed weight is 1.0 (else 0)
  } side_t;

  // quarter-wave sine entry k of a 2^bits table, Q0.16, via Q30 Taylor series
  function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    x = (64'd1686629713 * 64'(k)) >> bits;
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        default: term = term / 210;
      endcase
      if (n % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
      else sum = sum + term;
    end
    sum = (sum * 64'd65536 + (64'd1 << 29)) >> 30;
    return (sum > 64'd65536) ? ONE_Q16 : sum[16:0];
  endfunction

  function automatic logic [23:0] sat24(input logic signed [27:0] v);
    if (v < -28'sd8388608) return 24'h800000;
    if (v > 28'sd8388607) return 24'h7FFFFF;
    return v[23:0];
  endfunction

endpackage

>>> sv/tbv_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on tbv_pkg.
module tbv_sqrt
  import tbv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [D2_W-1:0]   in_rad,
  input  side_t             in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_root,
  output side_t             out_side
);

  localparam int NS = DIST_W;

  logic            v_r   [NS];
  logic            en    [NS+1];
  logic [D2_W-1:0] rem_r [NS];
  logic [D2_W-1:0] res_r [NS];
  side_t           side_r[NS];

  assign en[NS] = out_ready;

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam logic [D2_W-1:0] BIT = D2_W'(1) << (2 * (NS - 1 - s));
    logic            up_v;
    logic [D2_W-1:0] rem_i;
    logic [D2_W-1:0] res_i;
    logic [D2_W-1:0] trial;
    side_t           side_i;

    if (s == 0) begin : g_first
      assign up_v   = in_valid;
      assign rem_i  = in_rad;
      assign res_i  = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign up_v   = v_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign res_i  = res_r[s-1];
      assign side_i = side_r[s-1];
    end

    assign en[s] = !v_r[s] || en[s+1];
    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= up_v;
      end
      if (en[s]) begin
        side_r[s] <= side_i;
        if (rem_i >= trial) begin
          rem_r[s] <= rem_i - trial;
          res_r[s] <= (res_i >> 1) + BIT;
        end else begin
          rem_r[s] <= rem_i;
          res_r[s] <= res_i >> 1;
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_root  = res_r[NS-1][DIST_W-1:0];
  assign out_side  = side_r[NS-1];

endmodule

>>> sv/tbv_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, quotient saturated to 1.0 in Q0.16.
// Depends on tbv_pkg.
module tbv_div
  import tbv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Q_W-1:0]   out_quo,
  output side_t            out_side
);

  localparam int NS    = Q_W + 1;
  localparam int REM_W = DEN_W + Q_W;

  logic             v_r   [NS];
  logic             en    [NS+1];
  logic             sat_r [NS];
  logic [REM_W-1:0] rem_r [NS];
  logic [Q_W-1:0]   q_r   [NS];
  logic [DEN_W-1:0] den_r [NS];
  side_t            side_r[NS];

  assign en[NS] = out_ready;

  // first stage: quotient of 2.0 or more saturates outright
  assign en[0] = !v_r[0] || en[1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
    if (en[0]) begin
      sat_r[0]  <= in_num >= NUM_W'({in_den, {Q_W{1'b0}}});
      rem_r[0]  <= in_num[REM_W-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_st
    localparam int K = Q_W - s;
    logic [REM_W-1:0] sub;

    assign en[s] = !v_r[s] || en[s+1];
    assign sub   = REM_W'(den_r[s-1]) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_r[s-1];
      end
      if (en[s]) begin
        sat_r[s]  <= sat_r[s-1];
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
        if (rem_r[s-1] >= sub) begin
          rem_r[s] <= rem_r[s-1] - sub;
          q_r[s]   <= q_r[s-1] | (Q_W'(1) << K);
        end else begin
          rem_r[s] <= rem_r[s-1];
          q_r[s]   <= q_r[s-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_quo   = (sat_r[NS-1] || q_r[NS-1] > ONE_Q16) ? ONE_Q16 : q_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

>>> sv/terrain_brush_vertex_update.sv
`timescale 1ns / 1ps
// Terrain brush vertex update: xz distance, brush falloff weight, height and blend update.
// One word per cycle sustained while the receiver keeps out_tready high.
// Most of the depth is set by the square root (one bit per stage) and the divider (one quotient
// bit per stage). Every stage stalls only when it and all stages after it are full.
// Synchronous active-low reset clears the valid bits and loads the register defaults.
// Depends on tbv_pkg, tbv_sqrt, tbv_div.
module terrain_brush_vertex_update
  import tbv_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vertex_x, vertex_z, vertex_height, blend_weight, center_x, center_z, time_step
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_height, new_blend_weight, brush_weight
  output logic [71:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);

  localparam int SH      = 16 - SINE_TABLE_BITS;
  localparam int IDX_W   = SINE_TABLE_BITS + 1;
  localparam int LUT_TOP = 1 << SINE_TABLE_BITS;

  // ---------------- configuration
  logic        shape_r;
  logic [1:0]  fall_r;
  logic [18:0] radius_r;
  logic [23:0] gain_r;
  logic [11:0] fill_r;
  logic        paint_r;
  logic [23:0] floor_r;
  logic [23:0] ceil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= 1'b0;
      fall_r   <= FALL_HARD;
      radius_r <= '0;
      gain_r   <= '0;
      fill_r   <= 12'd256;
      paint_r  <= 1'b0;
      floor_r  <= 24'h800000;
      ceil_r   <= 24'h7FFFFF;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHAPE:   shape_r  <= cfg_wdata[0];
        CFG_FALLOFF: fall_r   <= cfg_wdata[1:0];
        CFG_RADIUS:  radius_r <= cfg_wdata[18:0];
        CFG_GAIN:    gain_r   <= cfg_wdata;
        CFG_FILL:    fill_r   <= cfg_wdata[11:0];
        CFG_PAINT:   paint_r  <= cfg_wdata[0];
        CFG_FLOOR:   floor_r  <= cfg_wdata;
        CFG_CEIL:    ceil_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic        gneg;
  logic [23:0] gmag;
  assign gneg = gain_r[23];
  assign gmag = gneg ? 24'(-gain_r) : gain_r;

  // ---------------- sine table
  logic [16:0] sine_lut [LUT_TOP+1];
  for (genvar k = 0; k <= LUT_TOP; k++) begin : g_lut
    assign sine_lut[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  // ---------------- front: differences, squares, flags
  logic va_r [5];
  logic ena  [6];
  logic sq_in_ready;

  assign ena[5] = sq_in_ready;
  for (genvar i = 0; i < 5; i++) begin : g_ena
    assign ena[i] = !va_r[i] || ena[i+1];
  end
  assign in_tready = ena[0];

  logic [24:0]     a0_dx_r, a0_dz_r;
  side_t           a0_side_r, a1_side_r, a2_side_r, a3_side_r, a4_side_r;
  logic [24:0]     a1_ax_r, a1_az_r;
  logic [D2_W-1:0] a2_ax2_r, a2_az2_r;
  logic [37:0]     a2_rr_r, a3_rr_r;
  logic            a2_box_r, a3_box_r;
  logic [D2_W-1:0] a3_d2_r, a4_d2_r;

  side_t in_side;
  always_comb begin
    in_side        = '0;
    in_side.h      = in_tdata[71:48];
    in_side.b      = in_tdata[88:72];
    in_side.dt     = in_tdata[152:137];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) va_r[i] <= 1'b0;
    end else begin
      if (ena[0]) va_r[0] <= in_tvalid;
      for (int i = 1; i < 5; i++) if (ena[i]) va_r[i] <= va_r[i-1];
    end
  end

  logic kill_a4;
  assign kill_a4 = (radius_r == '0) || (fall_r == FALL_NONE)
                   || (shape_r == SHAPE_SQUARE && !a3_box_r);

  side_t a4_side_nxt;
  always_comb begin
    a4_side_nxt        = a3_side_r;
    a4_side_nxt.wforce = kill_a4 || (fall_r == FALL_HARD);
    a4_side_nxt.wone   = !kill_a4
                         && (shape_r == SHAPE_SQUARE || a3_d2_r < D2_W'(a3_rr_r));
  end

  always_ff @(posedge clk) begin
    if (ena[0]) begin
      a0_dx_r   <= {in_tdata[23], in_tdata[23:0]} - {in_tdata[112], in_tdata[112:89]};
      a0_dz_r   <= {in_tdata[47], in_tdata[47:24]} - {in_tdata[136], in_tdata[136:113]};
      a0_side_r <= in_side;
    end
    if (ena[1]) begin
      a1_ax_r   <= a0_dx_r[24] ? 25'(-a0_dx_r) : a0_dx_r;
      a1_az_r   <= a0_dz_r[24] ? 25'(-a0_dz_r) : a0_dz_r;
      a1_side_r <= a0_side_r;
    end
    if (ena[2]) begin
      a2_ax2_r  <= D2_W'(a1_ax_r) * D2_W'(a1_ax_r);
      a2_az2_r  <= D2_W'(a1_az_r) * D2_W'(a1_az_r);
      a2_rr_r   <= 38'(radius_r) * 38'(radius_r);
      a2_box_r  <= (a1_ax_r < 25'(radius_r)) && (a1_az_r < 25'(radius_r));
      a2_side_r <= a1_side_r;
    end
    if (ena[3]) begin
      a3_d2_r   <= a2_ax2_r + a2_az2_r;
      a3_rr_r   <= a2_rr_r;
      a3_box_r  <= a2_box_r;
      a3_side_r <= a2_side_r;
    end
    if (ena[4]) begin
      a4_d2_r   <= a3_d2_r;
      a4_side_r <= a4_side_nxt;
    end
  end

  // ---------------- square root
  logic              sq_out_valid;
  logic              sq_out_ready;
  logic [DIST_W-1:0] sq_root;
  side_t             sq_side;

  tbv_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r[4]),
    .in_ready  (sq_in_ready),
    .in_rad    (a4_d2_r),
    .in_side   (a4_side_r),
    .out_valid (sq_out_valid),
    .out_ready (sq_out_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------- divider operands
  logic             vb_r;
  logic             enb;
  logic             dv_in_ready;
  logic [34:0]      b_num_r;
  logic [DEN_W-1:0] b_den_r;
  side_t            b_side_r;

  assign enb          = !vb_r || dv_in_ready;
  assign sq_out_ready = enb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (enb) begin
      vb_r <= sq_out_valid;
    end
    if (enb) begin
      // square: dist / (r * 1.414) as dist*1000 / (r*1414)
      b_num_r  <= (shape_r == SHAPE_SQUARE) ? 35'(sq_root) * 35'd1000 : 35'(sq_root);
      b_den_r  <= (shape_r == SHAPE_SQUARE) ? DEN_W'(radius_r) * DEN_W'(1414)
                                            : DEN_W'(radius_r);
      b_side_r <= sq_side;
    end
  end

  logic           dv_out_valid;
  logic [Q_W-1:0] dv_quo;
  side_t          dv_side;
  logic           enc [10];

  tbv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_ready  (dv_in_ready),
    .in_num    ({b_num_r, 16'b0}),
    .in_den    (b_den_r),
    .in_side   (b_side_r),
    .out_valid (dv_out_valid),
    .out_ready (enc[0]),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // ---------------- back: easing, weight, update, clamp
  logic vc_r [9];

  assign enc[9] = out_tready;
  for (genvar i = 0; i < 9; i++) begin : g_enc
    assign enc[i] = !vc_r[i] || enc[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) vc_r[i] <= 1'b0;
    end else begin
      if (enc[0]) vc_r[0] <= dv_out_valid;
      for (int i = 1; i < 9; i++) if (enc[i]) vc_r[i] <= vc_r[i-1];
    end
  end

  side_t          c0_side_r, c1_side_r, c2_side_r, c3_side_r, c4_side_r, c5_side_r, c6_side_r;
  logic [16:0]    c0_lin_r, c1_lin_r, c2_lin_r;
  logic [16:0]    c1_e0_r, c2_e0_r;
  logic [16:0]    c1_diff_r;
  logic [SH-1:0]  c1_frac_r;
  logic [16+SH:0] c2_prod_r;
  logic [16:0]    c3_w_r, c4_w_r, c5_w_r, c6_w_r, c7_w_r;
  logic [40:0]    c4_wg_r;
  logic [28:0]    c4_wf_r;
  logic [56:0]    c5_pg_r;
  logic [44:0]    c5_pf_r;
  logic [25:0]    c6_dh_r;
  logic [21:0]    c6_db_r;
  logic [23:0]    c7_h_r, c7_b_r;
  logic [23:0]    out_h_r, out_b_r;
  logic [16:0]    out_w_r;

  logic [IDX_W-1:0] idx;
  logic [16:0]      e0, e1;
  logic [16:0]      sine_w;
  logic [57:0]      pg_rnd;
  logic [45:0]      pf_rnd;
  logic [27:0]      hsum, bsum;
  logic [23:0]      hclamp, bclamp;

  assign idx = c0_lin_r[16:SH];

  always_comb begin
    if (idx[IDX_W-1]) begin
      e0 = sine_lut[LUT_TOP];
      e1 = sine_lut[LUT_TOP];
    end else begin
      e0 = sine_lut[idx];
      e1 = sine_lut[idx + IDX_W'(1)];
    end
  end

  assign sine_w = c2_e0_r + 17'(c2_prod_r >> SH);
  assign pg_rnd = {1'b0, c5_pg_r} + (58'd1 << 31);
  assign pf_rnd = {1'b0, c5_pf_r} + (46'd1 << 23);

  assign hsum = gneg ? {{4{c6_side_r.h[23]}}, c6_side_r.h} - {2'b0, c6_dh_r}
                     : {{4{c6_side_r.h[23]}}, c6_side_r.h} + {2'b0, c6_dh_r};
  assign bsum = paint_r ? {11'b0, c6_side_r.b} + {6'b0, c6_db_r}
                        : {11'b0, c6_side_r.b} - {6'b0, c6_db_r};

  always_comb begin
    hclamp = c7_h_r;
    bclamp = c7_b_r;
    if (c7_w_r != '0) begin
      if (bclamp[23]) bclamp = '0;
      else if (bclamp > 24'(ONE_Q16)) bclamp = 24'(ONE_Q16);
      // floor first, so inverted limits end at the ceiling
      if ($signed(hclamp) < $signed(floor_r)) hclamp = floor_r;
      if ($signed(hclamp) > $signed(ceil_r)) hclamp = ceil_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enc[0]) begin
      c0_lin_r  <= ONE_Q16 - dv_quo;
      c0_side_r <= dv_side;
    end
    if (enc[1]) begin
      c1_e0_r   <= e0;
      c1_diff_r <= (e1 > e0) ? e1 - e0 : '0;
      c1_frac_r <= c0_lin_r[SH-1:0];
      c1_lin_r  <= c0_lin_r;
      c1_side_r <= c0_side_r;
    end
    if (enc[2]) begin
      c2_prod_r <= (17+SH)'(c1_diff_r) * (17+SH)'(c1_frac_r);
      c2_e0_r   <= c1_e0_r;
      c2_lin_r  <= c1_lin_r;
      c2_side_r <= c1_side_r;
    end
    if (enc[3]) begin
      if (c2_side_r.wforce) c3_w_r <= c2_side_r.wone ? ONE_Q16 : '0;
      else if (fall_r == FALL_LINEAR) c3_w_r <= c2_lin_r;
      else c3_w_r <= sine_w;
      c3_side_r <= c2_side_r;
    end
    if (enc[4]) begin
      c4_wg_r   <= 41'(c3_w_r) * 41'(gmag);
      c4_wf_r   <= 29'(c3_w_r) * 29'(fill_r);
      c4_w_r    <= c3_w_r;
      c4_side_r <= c3_side_r;
    end
    if (enc[5]) begin
      c5_pg_r   <= 57'(c4_wg_r) * 57'(c4_side_r.dt);
      c5_pf_r   <= 45'(c4_wf_r) * 45'(c4_side_r.dt);
      c5_w_r    <= c4_w_r;
      c5_side_r <= c4_side_r;
    end
    if (enc[6]) begin
      c6_dh_r   <= pg_rnd[57:32];
      c6_db_r   <= pf_rnd[45:24];
      c6_w_r    <= c5_w_r;
      c6_side_r <= c5_side_r;
    end
    if (enc[7]) begin
      c7_h_r <= sat24(hsum);
      c7_b_r <= sat24(bsum);
      c7_w_r <= c6_w_r;
    end
    if (enc[8]) begin
      out_h_r <= hclamp;
      out_b_r <= bclamp;
      out_w_r <= c7_w_r;
    end
  end

  assign out_tvalid = vc_r[8];
  assign out_tdata  = {7'b0, out_w_r, out_b_r, out_h_r};

  // ---------------- checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r[3] |-> c3_w_r <= ONE_Q16)
    else $error("brush weight above 1.0");

  a_blend_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_w_r != '0) |-> (!out_b_r[23] && out_b_r <= 24'(ONE_Q16)))
    else $error("blend weight not clamped under the brush");

endmodule

>>> dv/terrain_brush_vertex_update_test.sv
`timescale 1ns / 1ps
// Self-checking bench for terrain_brush_vertex_update: directed table, then random vertex
// words under several brush settings, checked against an in-bench weight/height model.
// Depends on tbv_pkg and the block RTL.
module terrain_brush_vertex_update_test;
  import tbv_pkg::*;

  localparam int SINE_BITS = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int EXP_DEPTH = 1024;

  typedef struct packed {
    logic [15:0] dt;
    logic [23:0] cz;
    logic [23:0] cx;
    logic [16:0] b;
    logic [23:0] h;
    logic [23:0] vz;
    logic [23:0] vx;
  } vertex_t;

  typedef struct packed {
    logic [16:0] w;
    logic [23:0] b;
    logic [23:0] h;
  } update_t;

  typedef struct {
    vertex_t v;
    logic    known;
    update_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_SHAPE;
  logic [23:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  terrain_brush_vertex_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // brush settings mirrored in the bench
  logic        m_shape;
  logic [1:0]  m_fall;
  logic [18:0] m_radius;
  logic [23:0] m_gain;
  logic [11:0] m_fill;
  logic        m_paint;
  logic [23:0] m_floor, m_ceil;

  // expected words, written at input accept and read at output accept
  update_t exp_mem[EXP_DEPTH];
  logic    exp_known[EXP_DEPTH];
  update_t exp_typed[EXP_DEPTH];
  int      exp_wr = 0, exp_rd = 0;
  logic    drv_known = 1'b0;
  update_t drv_res = '0;

  int errors = 0;
  int n_vertices = 0, n_updates = 0, n_touched = 0;
  logic [16:0] sine_lut[0:(1 << SINE_BITS)];

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r = 0, bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else r >>= 1;
      bitv >>= 2;
    end
    return r;
  endfunction

  // quarter-wave Taylor sine, Q30 internally, Q0.16 out
  function automatic logic [16:0] sine_q16(input longint unsigned k);
    longint unsigned x, term, acc;
    x = (64'd1686629713 * k) >> SINE_BITS;
    term = x;
    acc = x;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) acc = (acc >= term) ? acc - term : 0;
      else acc = acc + term;
    end
    acc = (acc * 65536 + (64'd1 << 29)) >> 30;
    return (acc > 65536) ? 17'h10000 : acc[16:0];
  endfunction

  function automatic longint unsigned eased_weight(input longint unsigned lin);
    int sh = 16 - SINE_BITS;
    longint unsigned idx = lin >> sh, frac = lin & ((64'd1 << sh) - 1);
    longint unsigned e0, e1;
    if (idx >= (1 << SINE_BITS)) return sine_lut[1 << SINE_BITS];
    e0 = sine_lut[idx];
    e1 = sine_lut[idx + 1];
    if (e1 < e0) e1 = e0;
    return e0 + (((e1 - e0) * frac) >> sh);
  endfunction

  function automatic longint unsigned falloff_weight(input longint signed dx,
                                                     input longint signed dz);
    longint unsigned r = m_radius, ax, az, d2, span, t, lin;
    if (r == 0 || m_fall == FALL_NONE) return 0;
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    d2 = ax * ax + az * az;
    span = root_floor(d2);
    if (m_shape == SHAPE_SQUARE) begin
      if (!(ax < r && az < r)) return 0;
      if (m_fall == FALL_HARD) return 65536;
      t = (span * 65536 * 1000) / (r * 1414);
    end else begin
      if (m_fall == FALL_HARD) return d2 < r * r ? 65536 : 0;
      t = (span * 65536) / r;
    end
    if (t > 65536) t = 65536;
    lin = 65536 - t;
    return m_fall == FALL_LINEAR ? lin : eased_weight(lin);
  endfunction

  function automatic longint signed clip24(input longint signed v);
    return v < -8388608 ? -8388608 : (v > 8388607 ? 8388607 : v);
  endfunction

  function automatic update_t brush_update(input vertex_t v);
    update_t u;
    longint signed h, b, gain, lo, hi;
    longint unsigned w, gmag, dh, db;
    h = longint'($signed(v.h));
    b = longint'(v.b);
    w = falloff_weight(longint'($signed(v.vx)) - longint'($signed(v.cx)),
                       longint'($signed(v.vz)) - longint'($signed(v.cz)));
    gain = longint'($signed(m_gain));
    gmag = gain < 0 ? -gain : gain;
    dh = (w * gmag * v.dt + (64'd1 << 31)) >> 32;
    db = (w * m_fill * v.dt + (64'd1 << 23)) >> 24;
    h = clip24(gain < 0 ? h - longint'(dh) : h + longint'(dh));
    b = clip24(m_paint ? b + longint'(db) : b - longint'(db));
    if (w > 0) begin
      lo = longint'($signed(m_floor));
      hi = longint'($signed(m_ceil));
      if (b < 0) b = 0;
      if (b > 65536) b = 65536;
      if (h < lo) h = lo;
      if (h > hi) h = hi;
    end
    u.h = h[23:0];
    u.b = b[23:0];
    u.w = w[16:0];
    return u;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SHAPE:   m_shape = val[0];
      CFG_FALLOFF: m_fall = val[1:0];
      CFG_RADIUS:  m_radius = val[18:0];
      CFG_GAIN:    m_gain = val;
      CFG_FILL:    m_fill = val[11:0];
      CFG_PAINT:   m_paint = val[0];
      CFG_FLOOR:   m_floor = val;
      default:     m_ceil = val;
    endcase
  endtask

  task automatic set_brush(input logic shape, input logic [1:0] fall, input logic [18:0] rad,
                           input logic [23:0] gain, input logic [11:0] fill,
                           input logic paint, input logic [23:0] lo, input logic [23:0] hi);
    write_reg(CFG_SHAPE, 24'(shape));
    write_reg(CFG_FALLOFF, 24'(fall));
    write_reg(CFG_RADIUS, 24'(rad));
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_FILL, 24'(fill));
    write_reg(CFG_PAINT, 24'(paint));
    write_reg(CFG_FLOOR, lo);
    write_reg(CFG_CEIL, hi);
  endtask

  // sender idles until every expected word is back
  task automatic hold_until_empty();
    in_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  // wait for the pipe to empty before touching registers
  task automatic drain();
    hold_until_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays up after an accept when the next word follows with no gap
  task automatic send_vertex(input vertex_t v, input logic known = 1'b0,
                             input update_t res = '0);
    int gap;
    gap = $urandom_range(0, 6) * $urandom_range(0, 1);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= 160'(v);
    drv_known <= known;
    drv_res <= res;
    do @(posedge clk); while (!in_tready);
    n_vertices++;
  endtask

  // expectation stored at the accepting edge, before the result can appear
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      exp_mem[exp_wr % EXP_DEPTH] = brush_update(vertex_t'(in_tdata[152:0]));
      exp_known[exp_wr % EXP_DEPTH] = drv_known;
      exp_typed[exp_wr % EXP_DEPTH] = drv_res;
      exp_wr++;
    end
  end

  always @(posedge clk) begin
    update_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = update_t'(out_tdata[64:0]);
      n_updates++;
      if (got.w != 0) n_touched++;
      if (exp_wr == exp_rd) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        if (got.h !== want.h) begin
          errors++;
          $display("%0t: new_height exp %h got %h", $time, want.h, got.h);
        end
        if (got.b !== want.b) begin
          errors++;
          $display("%0t: new_blend_weight exp %h got %h", $time, want.b, got.b);
        end
        if (got.w !== want.w) begin
          errors++;
          $display("%0t: brush_weight exp %h got %h", $time, want.w, got.w);
        end
        if (exp_known[exp_rd % EXP_DEPTH] && got !== exp_typed[exp_rd % EXP_DEPTH]) begin
          errors++;
          $display("%0t: known word exp %h got %h", $time,
                   exp_typed[exp_rd % EXP_DEPTH], got);
        end
        exp_rd++;
      end
    end
  end

  // receiver stalls: random holds with calm stretches
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic vertex_t mk_vertex(input int vx, input int vz, input int h, input int b,
                                        input int cx, input int cz, input int dt);
    vertex_t v;
    v.vx = vx[23:0]; v.vz = vz[23:0]; v.h = h[23:0]; v.b = b[16:0];
    v.cx = cx[23:0]; v.cz = cz[23:0]; v.dt = dt[15:0];
    return v;
  endfunction

  function automatic vertex_t rand_vertex(input logic near);
    vertex_t v;
    int spread;
    v = vertex_t'(153'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    if (v.b > 17'h10000) v.b = 17'($urandom_range(0, 65536));
    if (near) begin
      // keep the vertex close to the center so the brush actually bites
      spread = int'(m_radius) + 64;
      v.cx = 24'($urandom_range(0, 24'hFFFFFF));
      v.cz = 24'($urandom_range(0, 24'hFFFFFF));
      v.vx = v.cx + 24'($urandom_range(0, 2 * spread) - spread);
      v.vz = v.cz + 24'($urandom_range(0, 2 * spread) - spread);
    end
    return v;
  endfunction

  initial begin
    stim_row_t rows[2];
    for (int k = 0; k <= (1 << SINE_BITS); k++) sine_lut[k] = sine_q16(k);
    m_shape = 0; m_fall = FALL_HARD; m_radius = 0; m_gain = 0; m_fill = 256; m_paint = 0;
    m_floor = 24'h800000; m_ceil = 24'h7FFFFF;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: zero range leaves everything untouched
    rows[0].known = 1;
    rows[0].v = mk_vertex(0, 0, 1234, 4000, 0, 0, 65535);
    rows[0].res = '{w: 17'd0, b: 24'd4000, h: 24'd1234};
    rows[1].known = 1;
    rows[1].v = mk_vertex(-8388608, 8388607, -8388608, 65536, 8388607, -8388608, 0);
    rows[1].res = '{w: 17'd0, b: 24'd65536, h: 24'h800000};
    foreach (rows[i]) send_vertex(rows[i].v, rows[i].known, rows[i].res);
    drain();

    // square, hard, extremes of gain and clamp
    set_brush(0, FALL_HARD, 19'd1024, 24'h7FFFFF, 12'd2560, 1, 24'hFFFF00, 24'd256);
    send_vertex(mk_vertex(0, 0, 0, 0, 0, 0, 65535), 1'b1,
                '{w: 17'h10000, b: 24'd65536, h: 24'd256});
    send_vertex(mk_vertex(1023, -1023, 100, 65536, 0, 0, 40000));
    send_vertex(mk_vertex(1024, 0, 100, 0, 0, 0, 65535));
    send_vertex(mk_vertex(8388607, 8388607, 8388607, 0, -8388608, -8388608, 65535));
    drain();
    // circle of each falloff, lowering paint, inverted limits, unused kind
    for (int f = 0; f < 4; f++) begin
      set_brush(1, 2'(f), 19'h7FFFF, 24'h800000, 12'd256, 0, 24'd5000, 24'd1000);
      send_vertex(mk_vertex(0, 0, 3000, 65536, 0, 0, 65535));
      send_vertex(mk_vertex(70000, 0, 3000, 100, 0, 0, 65535));
      send_vertex(mk_vertex(131071, 0, -8388608, 65536, 0, 0, 65535));
      send_vertex(mk_vertex(-200000, 300000, 8388607, 0, 0, 0, 1));
      drain();
    end
    // square linear and sine at one-unit range, odd fill rates
    set_brush(0, FALL_LINEAR, 19'd1, 24'd0, 12'd4095, 1, 24'h800000, 24'h7FFFFF);
    send_vertex(mk_vertex(0, 0, 0, 65536, 0, 0, 65535));
    drain();
    write_reg(CFG_FALLOFF, 24'(FALL_SINE));
    write_reg(CFG_FILL, 24'd0);
    send_vertex(mk_vertex(5, 5, 0, 65536, 5, 5, 65535));
    drain();

    // random phases over many brush settings
    for (int ph = 0; ph < 16; ph++) begin
      set_brush(1'($urandom_range(0, 1)), (ph % 5 == 4) ? FALL_NONE : 2'($urandom_range(0, 2)),
                (ph % 4 == 0) ? 19'h7FFFF : 19'($urandom_range(1, 8000)),
                24'($urandom), 12'($urandom_range(256, 2560)), 1'($urandom_range(0, 1)),
                24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
      if (ph % 3 == 0) begin
        write_reg(CFG_FLOOR, 24'h800000);
        write_reg(CFG_CEIL, 24'h7FFFFF);
      end
      for (int i = 0; i < 50; i++) begin
        send_vertex(rand_vertex($urandom_range(0, 9) < 8));
        // hold off until the pipe is empty once in a while
        if (i == 25 && ph % 4 == 1) hold_until_empty();
      end
      drain();
    end

    $display("covered %0d vertices, %0d updates, %0d with nonzero brush weight",
             n_vertices, n_updates, n_touched);
    if (errors == 0) $display("terrain_brush_vertex_update_test: done, clean");
    else $display("terrain_brush_vertex_update_test: done, errors");
    $finish;
  end

  initial begin
    #8000000;
    $display("terrain_brush_vertex_update_test: done, errors");
    $finish;
  end

endmodule
